### hw/rtl/sce_pkg.sv
// Shared types, constants, microcode and helpers for the stereo clarity enhancer.
`default_nettype none
package sce_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int GAIN_W    = 11;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int MUL_W     = SAMPLE_W + 1;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int STEP_W    = 4;
	localparam int GAIN_FRAC = 8;

	localparam logic signed [COEF_W-1:0] B0_RST = 16'sd2900;
	localparam logic signed [COEF_W-1:0] B1_RST = 16'sd5800;
	localparam logic signed [COEF_W-1:0] B2_RST = 16'sd2900;
	localparam logic signed [COEF_W-1:0] A1_RST = -16'sd8354;
	localparam logic signed [COEF_W-1:0] A2_RST = 16'sd3569;
	localparam logic [GAIN_W-1:0]        GAIN_RST = 11'd512;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0   = 3'd0,
		REG_B1   = 3'd1,
		REG_B2   = 3'd2,
		REG_A1   = 3'd3,
		REG_A2   = 3'd4,
		REG_GAIN = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		A_X, A_XH0, A_XH1, A_YH0, A_YH1, A_DIFF
	} a_sel_t;

	typedef enum logic [2:0] {
		B_B0, B_B1, B_B2, B_A1, B_A2, B_GAIN
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
	} acc_op_t;

	// STAGE_END loops to jmp_tgt while stages remain; CHAN_END loops for the right channel
	typedef enum logic [1:0] {
		ACT_NONE, ACT_STAGE_END, ACT_DIFF, ACT_CHAN_END
	} act_t;

	typedef struct packed {
		a_sel_t              a_sel;
		b_sel_t              b_sel;
		acc_op_t             acc_op;
		act_t                act;
		logic [STEP_W-1:0]   jmp_tgt;
	} uword_t;

	localparam logic [STEP_W-1:0] UA_BIQUAD = 4'd0;

	// acc_op applies to the product issued by the previous step
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{a_sel: A_X, b_sel: B_B0, acc_op: ACC_HOLD, act: ACT_NONE, jmp_tgt: UA_BIQUAD};
		case (step)
			4'd0: begin w.a_sel = A_X;    w.b_sel = B_B0; end
			4'd1: begin w.a_sel = A_XH0;  w.b_sel = B_B1; w.acc_op = ACC_LOAD; end
			4'd2: begin w.a_sel = A_XH1;  w.b_sel = B_B2; w.acc_op = ACC_ADD; end
			4'd3: begin w.a_sel = A_YH0;  w.b_sel = B_A1; w.acc_op = ACC_ADD; end
			4'd4: begin w.a_sel = A_YH1;  w.b_sel = B_A2; w.acc_op = ACC_SUB; end
			4'd5: begin w.acc_op = ACC_SUB; end
			4'd6: begin w.act = ACT_STAGE_END; end
			4'd7: begin w.a_sel = A_DIFF; w.b_sel = B_GAIN; w.act = ACT_DIFF; end
			4'd8: begin w.acc_op = ACC_LOAD; end
			4'd9: begin w.act = ACT_CHAN_END; end
			default: begin w.act = ACT_NONE; end
		endcase
		return w;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed({{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}});
		lo = -hi - $signed(ACC_W'(1));
		if (v > hi)
			return hi[SAMPLE_W-1:0];
		else if (v < lo)
			return lo[SAMPLE_W-1:0];
		else
			return v[SAMPLE_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/sce_ifs.sv
// Valid/ready channel interfaces for sample, result and register-write items.
`default_nettype none
interface sce_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sce_pkg::SAMPLE_W-1:0]  left_sample;
	logic signed [sce_pkg::SAMPLE_W-1:0]  right_sample;
	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface sce_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sce_pkg::SAMPLE_W-1:0]  left_out;
	logic signed [sce_pkg::SAMPLE_W-1:0]  right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface sce_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sce_pkg::REG_IDX_W-1:0]        idx;
	logic [sce_pkg::CFG_W-1:0]            wdata;
	modport source (output valid, idx, wdata, input ready);
	modport sink   (input valid, idx, wdata, output ready);
endinterface
`default_nettype wire

### hw/rtl/stereo_clarity_enhancer_top.sv
// Stereo clarity enhancer: microcoded biquad low-pass and difference gain, one shared MAC.
// With zero gain the input pair is passed straight through, unfiltered. A new item is taken
// the cycle after a result is loaded, so one item is in work at a time, paced by the single
// 17x17 MAC sequence, which holds at its last step while the previous result is still unread.
// Reset (arst_n low) restores default coefficients and gain and zeroes all filter history;
// a gain write also zeroes the history. Register writes are always accepted.
`default_nettype none
module stereo_clarity_enhancer_top #(
	parameter int COEF_FRAC_BITS = 14,
	parameter int CASCADE_STAGES = 1
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sce_in_if.sink      samples,
	sce_out_if.source   results,
	sce_cfg_if.sink     cfg
);

	localparam int SW    = sce_pkg::SAMPLE_W;
	localparam int AW    = sce_pkg::ACC_W;
	localparam int STG_W = (CASCADE_STAGES > 1) ? $clog2(CASCADE_STAGES) : 1;
	localparam logic [STG_W-1:0] STG_LAST = STG_W'(CASCADE_STAGES - 1);

	logic signed [sce_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [sce_pkg::GAIN_W-1:0]        gain_q;

	logic signed [SW-1:0] xh_q [2][CASCADE_STAGES][2];
	logic signed [SW-1:0] yh_q [2][CASCADE_STAGES][2];
	logic signed [SW-1:0] prev_q [2];
	logic signed [SW-1:0] in_q [2];
	logic signed [SW-1:0] x_q;
	logic signed [SW-1:0] res0_q;
	logic signed [SW-1:0] lout_q, rout_q;

	logic                         busy_q, out_valid_q, ch_q;
	logic [STG_W-1:0]             stg_q;
	logic [sce_pkg::STEP_W-1:0]   step_q;
	logic signed [sce_pkg::PROD_W-1:0] prod_s1;
	logic signed [AW-1:0]         acc_q;

	sce_pkg::uword_t              uw;
	logic                         accept, gain_wr, bypass, fin, adv, stg_more;
	logic signed [sce_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [AW-1:0]         bq_rnd, bq_sh, enh_rnd, enh_q, enh_sum;
	logic signed [SW-1:0]         bq_y, enh_y;

	assign uw       = sce_pkg::ucode(step_q);
	assign accept   = samples.valid && samples.ready;
	assign gain_wr  = cfg.valid && cfg.ready &&
		(sce_pkg::reg_idx_t'(cfg.idx) == sce_pkg::REG_GAIN);
	assign bypass   = (gain_q == '0);
	assign fin      = busy_q && (bypass || (uw.act == sce_pkg::ACT_CHAN_END && ch_q));
	assign adv      = busy_q && !(fin && out_valid_q && !results.ready);
	assign stg_more = (stg_q != STG_LAST);

	assign samples.ready     = !busy_q;
	assign cfg.ready         = 1'b1;
	assign results.valid     = out_valid_q;
	assign results.left_out  = lout_q;
	assign results.right_out = rout_q;

	always_comb begin
		case (uw.a_sel)
			sce_pkg::A_X:    mul_a = (sce_pkg::MUL_W)'(x_q);
			sce_pkg::A_XH0:  mul_a = (sce_pkg::MUL_W)'(xh_q[ch_q][stg_q][0]);
			sce_pkg::A_XH1:  mul_a = (sce_pkg::MUL_W)'(xh_q[ch_q][stg_q][1]);
			sce_pkg::A_YH0:  mul_a = (sce_pkg::MUL_W)'(yh_q[ch_q][stg_q][0]);
			sce_pkg::A_YH1:  mul_a = (sce_pkg::MUL_W)'(yh_q[ch_q][stg_q][1]);
			sce_pkg::A_DIFF: mul_a = (sce_pkg::MUL_W)'(prev_q[ch_q]) - (sce_pkg::MUL_W)'(x_q);
			default:         mul_a = '0;
		endcase
		case (uw.b_sel)
			sce_pkg::B_B0:   mul_b = (sce_pkg::MUL_W)'(b0_q);
			sce_pkg::B_B1:   mul_b = (sce_pkg::MUL_W)'(b1_q);
			sce_pkg::B_B2:   mul_b = (sce_pkg::MUL_W)'(b2_q);
			sce_pkg::B_A1:   mul_b = (sce_pkg::MUL_W)'(a1_q);
			sce_pkg::B_A2:   mul_b = (sce_pkg::MUL_W)'(a2_q);
			sce_pkg::B_GAIN: mul_b = $signed({{(sce_pkg::MUL_W-sce_pkg::GAIN_W){1'b0}}, gain_q});
			default:         mul_b = '0;
		endcase
	end

	// round half up, floor shift, saturate
	assign bq_rnd  = acc_q + $signed(AW'(1) << (COEF_FRAC_BITS - 1));
	assign bq_sh   = bq_rnd >>> COEF_FRAC_BITS;
	assign bq_y    = sce_pkg::sat_s(bq_sh);
	assign enh_rnd = acc_q + $signed(AW'(1) << (sce_pkg::GAIN_FRAC - 1));
	assign enh_q   = enh_rnd >>> sce_pkg::GAIN_FRAC;
	assign enh_sum = AW'(in_q[ch_q]) + enh_q;
	assign enh_y   = sce_pkg::sat_s(enh_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= sce_pkg::B0_RST;
			b1_q   <= sce_pkg::B1_RST;
			b2_q   <= sce_pkg::B2_RST;
			a1_q   <= sce_pkg::A1_RST;
			a2_q   <= sce_pkg::A2_RST;
			gain_q <= sce_pkg::GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (sce_pkg::reg_idx_t'(cfg.idx))
				sce_pkg::REG_B0:   b0_q   <= $signed(cfg.wdata[sce_pkg::COEF_W-1:0]);
				sce_pkg::REG_B1:   b1_q   <= $signed(cfg.wdata[sce_pkg::COEF_W-1:0]);
				sce_pkg::REG_B2:   b2_q   <= $signed(cfg.wdata[sce_pkg::COEF_W-1:0]);
				sce_pkg::REG_A1:   a1_q   <= $signed(cfg.wdata[sce_pkg::COEF_W-1:0]);
				sce_pkg::REG_A2:   a2_q   <= $signed(cfg.wdata[sce_pkg::COEF_W-1:0]);
				sce_pkg::REG_GAIN: gain_q <= cfg.wdata[sce_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				prev_q[c] <= '0;
				for (int s = 0; s < CASCADE_STAGES; s++) begin
					for (int t = 0; t < 2; t++) begin
						xh_q[c][s][t] <= '0;
						yh_q[c][s][t] <= '0;
					end
				end
			end
		end else if (gain_wr) begin
			for (int c = 0; c < 2; c++) begin
				prev_q[c] <= '0;
				for (int s = 0; s < CASCADE_STAGES; s++) begin
					for (int t = 0; t < 2; t++) begin
						xh_q[c][s][t] <= '0;
						yh_q[c][s][t] <= '0;
					end
				end
			end
		end else if (adv && !bypass) begin
			if (uw.act == sce_pkg::ACT_STAGE_END) begin
				xh_q[ch_q][stg_q][1] <= xh_q[ch_q][stg_q][0];
				xh_q[ch_q][stg_q][0] <= x_q;
				yh_q[ch_q][stg_q][1] <= yh_q[ch_q][stg_q][0];
				yh_q[ch_q][stg_q][0] <= bq_y;
			end
			if (uw.act == sce_pkg::ACT_DIFF)
				prev_q[ch_q] <= x_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			ch_q        <= 1'b0;
			stg_q       <= '0;
			step_q      <= sce_pkg::UA_BIQUAD;
		end else begin
			if (adv && fin)
				out_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				ch_q   <= 1'b0;
				stg_q  <= '0;
				step_q <= sce_pkg::UA_BIQUAD;
			end else if (adv) begin
				if (fin) begin
					busy_q <= 1'b0;
				end else begin
					case (uw.act)
						sce_pkg::ACT_STAGE_END: begin
							if (stg_more) begin
								stg_q  <= stg_q + 1'b1;
								step_q <= uw.jmp_tgt;
							end else begin
								stg_q  <= '0;
								step_q <= step_q + 1'b1;
							end
						end
						sce_pkg::ACT_CHAN_END: begin
							ch_q   <= 1'b1;
							stg_q  <= '0;
							step_q <= uw.jmp_tgt;
						end
						default: step_q <= step_q + 1'b1;
					endcase
				end
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= samples.left_sample;
			in_q[1] <= samples.right_sample;
			x_q     <= samples.left_sample;
		end else if (adv) begin
			prod_s1 <= mul_a * mul_b;
			case (uw.acc_op)
				sce_pkg::ACC_LOAD: acc_q <= AW'(prod_s1);
				sce_pkg::ACC_ADD:  acc_q <= acc_q + AW'(prod_s1);
				sce_pkg::ACC_SUB:  acc_q <= acc_q - AW'(prod_s1);
				default:           acc_q <= acc_q;
			endcase
			if (uw.act == sce_pkg::ACT_STAGE_END)
				x_q <= bq_y;
			if (uw.act == sce_pkg::ACT_CHAN_END && !ch_q) begin
				res0_q <= enh_y;
				x_q    <= in_q[1];
			end
			if (fin) begin
				lout_q <= bypass ? in_q[0] : res0_q;
				rout_q <= bypass ? in_q[1] : enh_y;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/sce_checker.sv
// Port-level checks for the stereo clarity enhancer, bound to the top level.
`default_nettype none
module sce_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [sce_pkg::SAMPLE_W-1:0] left_out,
	input wire logic signed [sce_pkg::SAMPLE_W-1:0] right_out
);

	// one item in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

	// a result only appears as the sequencer frees up
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while still busy");

	a_no_result_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && in_ready) |=> !out_valid)
		else $error("result with no item in work");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled item changed");

endmodule

bind stereo_clarity_enhancer_top sce_checker u_sce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.left_out  (results.left_out),
	.right_out (results.right_out)
);
`default_nettype wire

### test/sce_checker.sv
// Scoreboard for the stereo clarity enhancer: tracks register writes, predicts each pair, checks results.
module sce_scoreboard (
	input  wire logic clk,
	input  wire logic arst_n,
	sce_in_if         samples,
	sce_out_if        results,
	sce_cfg_if        cfg,
	output int        mismatches,
	output int        outstanding
);

	localparam int SAMPLE_W  = sce_pkg::SAMPLE_W;
	localparam int COEF_W    = sce_pkg::COEF_W;
	localparam int GAIN_W    = sce_pkg::GAIN_W;
	localparam int GAIN_FRAC = sce_pkg::GAIN_FRAC;
	localparam int COEF_FRAC = 14;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] l_out;
		logic signed [SAMPLE_W-1:0] r_out;
	} stereo_pair_t;

	logic signed [COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	logic [GAIN_W-1:0]          gain;
	logic signed [SAMPLE_W-1:0] in_hist [2][2];
	logic signed [SAMPLE_W-1:0] out_hist [2][2];
	logic signed [SAMPLE_W-1:0] last_lowpass [2];
	stereo_pair_t               enhanced_q [$];

	function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
		longint top_val;
		top_val = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
		if (v > top_val)
			return SAMPLE_W'(top_val);
		if (v < -top_val - 1)
			return SAMPLE_W'(-top_val - 1);
		return SAMPLE_W'(v);
	endfunction

	function automatic void clear_filters();
		for (int ch = 0; ch < 2; ch++) begin
			for (int k = 0; k < 2; k++) begin
				in_hist[ch][k]  = '0;
				out_hist[ch][k] = '0;
			end
			last_lowpass[ch] = '0;
		end
	endfunction

	// direct form I low-pass, then gain applied to the change in low-pass output
	function automatic logic signed [SAMPLE_W-1:0] enhance_chan(input int ch,
			input logic signed [SAMPLE_W-1:0] x);
		longint acc;
		longint lp;
		longint q;
		acc = longint'(coef_b0) * longint'(x)
			+ longint'(coef_b1) * longint'(in_hist[ch][0])
			+ longint'(coef_b2) * longint'(in_hist[ch][1])
			- longint'(coef_a1) * longint'(out_hist[ch][0])
			- longint'(coef_a2) * longint'(out_hist[ch][1]);
		lp = longint'(clip_sample((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC));
		in_hist[ch][1]  = in_hist[ch][0];
		in_hist[ch][0]  = x;
		out_hist[ch][1] = out_hist[ch][0];
		out_hist[ch][0] = SAMPLE_W'(lp);
		q = (longint'(last_lowpass[ch]) - lp) * longint'(gain);
		q = (q + 128) >>> GAIN_FRAC;
		last_lowpass[ch] = SAMPLE_W'(lp);
		return clip_sample(longint'(x) + q);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stereo_pair_t exp_pair;
		if (!arst_n) begin
			coef_b0 = sce_pkg::B0_RST;
			coef_b1 = sce_pkg::B1_RST;
			coef_b2 = sce_pkg::B2_RST;
			coef_a1 = sce_pkg::A1_RST;
			coef_a2 = sce_pkg::A2_RST;
			gain    = sce_pkg::GAIN_RST;
			clear_filters();
			enhanced_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (enhanced_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got left %0d right %0d",
						$time, results.left_out, results.right_out);
					mismatches++;
				end else begin
					exp_pair = enhanced_q.pop_front();
					if (results.left_out !== exp_pair.l_out) begin
						$display("%0t: left_out mismatch, expected %0d, got %0d",
							$time, exp_pair.l_out, results.left_out);
						mismatches++;
					end
					if (results.right_out !== exp_pair.r_out) begin
						$display("%0t: right_out mismatch, expected %0d, got %0d",
							$time, exp_pair.r_out, results.right_out);
						mismatches++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (sce_pkg::reg_idx_t'(cfg.idx))
					sce_pkg::REG_B0: coef_b0 = cfg.wdata;
					sce_pkg::REG_B1: coef_b1 = cfg.wdata;
					sce_pkg::REG_B2: coef_b2 = cfg.wdata;
					sce_pkg::REG_A1: coef_a1 = cfg.wdata;
					sce_pkg::REG_A2: coef_a2 = cfg.wdata;
					sce_pkg::REG_GAIN: begin
						gain = cfg.wdata[GAIN_W-1:0];
						clear_filters();
					end
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				// zero gain is a pure bypass, filter state untouched
				if (gain == '0) begin
					exp_pair.l_out = samples.left_sample;
					exp_pair.r_out = samples.right_sample;
				end else begin
					exp_pair.l_out = enhance_chan(0, samples.left_sample);
					exp_pair.r_out = enhance_chan(1, samples.right_sample);
				end
				enhanced_q.push_back(exp_pair);
			end
			outstanding = enhanced_q.size();
		end
	end

endmodule

### test/tb_top.sv
// Top-level testbench for the stereo clarity enhancer: clock, reset, stimulus, verdict.
module tb_top;

	localparam int SAMPLE_W  = sce_pkg::SAMPLE_W;
	localparam int REG_IDX_W = sce_pkg::REG_IDX_W;
	localparam int CFG_W     = sce_pkg::CFG_W;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 25;

	localparam logic [REG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'h7FFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'h8000;

	localparam logic [SAMPLE_W-1:0] DIR_L [20] = '{
		16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
		16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA,
		16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C};
	localparam logic [SAMPLE_W-1:0] DIR_R [20] = '{
		16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
		16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555,
		16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFF9C, 16'h0064};

	typedef struct {
		logic [REG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
	} reg_write_t;

	logic clk;
	logic arst_n;
	int   sent_cnt;
	int   got_cnt;
	int   settings;
	int   mismatches;
	int   outstanding;
	bit   no_idle;
	reg_write_t reg_writes [$];

	sce_in_if  samples();
	sce_out_if results();
	sce_cfg_if cfg();

	stereo_clarity_enhancer_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	sce_scoreboard sce_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.results     (results),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_word();
		return CFG_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.left_sample  <= l;
		samples.right_sample <= r;
		do @(posedge clk); while (!samples.ready);
		sent_cnt++;
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			send_pair(pick_sample(), pick_sample());
	endtask

	task automatic queue_coefs(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
			input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1, input logic [CFG_W-1:0] a2);
		reg_writes.push_back('{sce_pkg::REG_B0, b0});
		reg_writes.push_back('{sce_pkg::REG_B1, b1});
		reg_writes.push_back('{sce_pkg::REG_B2, b2});
		reg_writes.push_back('{sce_pkg::REG_A1, a1});
		reg_writes.push_back('{sce_pkg::REG_A2, a2});
	endtask

	// registers change only with the pipe empty
	task automatic flush_writes();
		reg_write_t w;
		samples.valid <= 1'b0;
		while (got_cnt != sent_cnt) @(posedge clk);
		repeat (2) @(posedge clk);
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg.valid <= 1'b1;
			cfg.idx   <= w.idx;
			cfg.wdata <= w.data;
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		settings++;
	endtask

	// result side: short random stalls plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		results.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && got_cnt >= HOLD_AT) begin
				held = 1'b1;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk);
			if (results.valid)
				got_cnt++;
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("stereo_clarity_enhancer_top verification failed");
		$finish;
	end

	initial begin
		sent_cnt = 0;
		got_cnt  = 0;
		settings = 1;
		no_idle  = 1'b0;
		arst_n               <= 1'b0;
		samples.valid        <= 1'b0;
		samples.left_sample  <= '0;
		samples.right_sample <= '0;
		cfg.valid            <= 1'b0;
		cfg.idx              <= '0;
		cfg.wdata            <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 20; i++)
			send_pair(DIR_L[i], DIR_R[i]);
		random_run(250);

		// coefficients only, history carries over
		queue_coefs(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		flush_writes();
		random_run(200);

		queue_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		reg_writes.push_back('{sce_pkg::REG_GAIN, 16'hFFFF});
		flush_writes();
		random_run(150);

		// upper bits dropped, gain lands on zero: bypass
		queue_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		reg_writes.push_back('{sce_pkg::REG_GAIN, 16'hF800});
		flush_writes();
		random_run(100);

		queue_coefs(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		reg_writes.push_back('{sce_pkg::REG_GAIN, 16'd1});
		flush_writes();
		random_run(200);

		reg_writes.push_back('{REG_SPARE6, rand_word()});
		reg_writes.push_back('{REG_SPARE7, rand_word()});
		queue_coefs(sce_pkg::B0_RST, sce_pkg::B1_RST, sce_pkg::B2_RST, sce_pkg::A1_RST,
			sce_pkg::A2_RST);
		reg_writes.push_back('{sce_pkg::REG_GAIN, 16'd1280});
		flush_writes();
		random_run(250);

		queue_coefs(CFG_W'(int'($urandom_range(0, 32767)) - 16384),
			CFG_W'(int'($urandom_range(0, 32767)) - 16384),
			CFG_W'(int'($urandom_range(0, 32767)) - 16384),
			CFG_W'(int'($urandom_range(0, 32767)) - 16384),
			CFG_W'(int'($urandom_range(0, 32767)) - 16384));
		reg_writes.push_back('{sce_pkg::REG_GAIN, 16'd512});
		flush_writes();
		random_run(200);

		queue_coefs(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		reg_writes.push_back('{sce_pkg::REG_GAIN, CFG_W'($urandom_range(512, 1280))});
		flush_writes();
		no_idle = 1'b1;
		random_run(300);

		samples.valid <= 1'b0;
		while (got_cnt != sent_cnt) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Streamed %0d stereo pairs over %0d register settings, with long output stall,",
			sent_cnt, settings);
		$display("zero and out-of-range gain, extreme coefficients and ignored register indexes.");
		if (outstanding != 0)
			$display("%0t: %0d expected results never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("stereo_clarity_enhancer_top verification clean");
		else
			$display("stereo_clarity_enhancer_top verification failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/sce_pkg.sv
hw/rtl/sce_ifs.sv
hw/rtl/stereo_clarity_enhancer_top.sv
hw/rtl/sce_checker.sv
test/sce_checker.sv
test/tb_top.sv
